### rtl/assert_macros.svh
// Assertion macros shared by the bounded line collector RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("blc assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("blc assertion failed");

`endif

### rtl/blc_pkg.sv
// Shared types and constants of the bounded line collector.
// Used by blc_core, blc_obuf and bounded_line_collector; no dependencies.
package blc_pkg;

    localparam int C_CFG_W     = 9;
    localparam int C_CFG_IDX_W = 1;

    localparam logic [7:0] C_LF_BYTE  = 8'h0A;
    localparam logic [7:0] C_CR_BYTE  = 8'h0D;
    localparam logic [7:0] C_NUL_BYTE = 8'h00;

    // Largest line store the design is built for, and the capacity clamp that follows.
    localparam int C_MAX_CAPACITY     = 256;
    localparam int C_CAP_LIMIT_INT    = (C_MAX_CAPACITY < 256) ? C_MAX_CAPACITY : 256;
    localparam logic [C_CFG_W-1:0] C_CAP_LIMIT     = C_CFG_W'(C_CAP_LIMIT_INT);
    localparam logic [C_CFG_W-1:0] C_CAP_RESET     = C_CFG_W'(256);
    localparam logic [C_CFG_W-1:0] C_CAP_MIN       = C_CFG_W'(2);

    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_CAPACITY = 1'b0,
        CFG_KEEP     = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_STORED   = 2'd0,
        EV_SKIPPED  = 2'd1,
        EV_DROPPED  = 2'd2,
        EV_COMPLETE = 2'd3
    } t_event;

    typedef struct packed {
        logic [7:0] line_len;
        logic [7:0] byte_value;
        logic [7:0] store_index;
        logic       byte_stored;
        t_event     event_res;
    } t_result;

endpackage

### rtl/blc_core.sv
// Per-byte decision logic, line state and configuration registers.
// Depends on blc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module blc_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [blc_pkg::C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [blc_pkg::C_CFG_W-1:0]     i_cfg_wdata,
    input  logic                            i_fire,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_raw_call,
    output logic                            o_res_valid,
    output blc_pkg::t_result                o_res
);
    import blc_pkg::*;

    logic [C_CFG_W-1:0] r_cap;
    logic               r_keep;
    logic [7:0]         r_count;
    logic [7:0]         r_crs;
    logic               r_disc;

    logic [7:0]         n_count;
    logic [7:0]         n_crs;
    logic               n_disc;

    logic [C_CFG_W-1:0] cap_eff;
    logic [C_CFG_W-1:0] cap_last;
    logic               enabled;
    logic               keep;
    logic               is_lf;
    logic               store_req;
    logic [7:0]         cnt1;
    logic [7:0]         crs1;
    logic [7:0]         cr_cut;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= C_CAP_RESET;
            r_keep <= 1'b0;
        end else if (i_cfg_wen) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CAPACITY: r_cap  <= i_cfg_wdata;
                CFG_KEEP:     r_keep <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cap_eff   = (r_cap > C_CAP_LIMIT) ? C_CAP_LIMIT : r_cap;
        cap_last  = cap_eff - C_CFG_W'(1);
        enabled   = (cap_eff >= C_CAP_MIN);
        keep      = i_raw_call | r_keep;
        is_lf     = (i_data_byte == C_LF_BYTE);
        store_req = !is_lf || keep;
        cnt1      = store_req ? (r_count + 8'd1) : r_count;
        crs1      = store_req ? ((i_data_byte == C_CR_BYTE) ? (r_crs + 8'd1) : 8'd0) : r_crs;
        cr_cut    = (crs1 <= cnt1) ? crs1 : cnt1;

        n_count = r_count;
        n_crs   = r_crs;
        n_disc  = r_disc;

        o_res.event_res   = EV_STORED;
        o_res.byte_stored = 1'b0;
        o_res.store_index = 8'd0;
        o_res.byte_value  = i_data_byte;
        o_res.line_len    = 8'd0;

        if (r_disc) begin
            o_res.event_res = EV_SKIPPED;
            if (is_lf) begin
                n_disc = 1'b0;
            end
        end else if ((i_data_byte == C_NUL_BYTE)
                     || (({1'b0, r_count} >= cap_last) && store_req)) begin
            o_res.event_res = EV_DROPPED;
            n_count = 8'd0;
            n_crs   = 8'd0;
            n_disc  = !is_lf;
        end else begin
            if (store_req) begin
                o_res.byte_stored = 1'b1;
                o_res.store_index = r_count;
            end
            if (is_lf) begin
                o_res.event_res = EV_COMPLETE;
                o_res.line_len  = keep ? cnt1 : (cnt1 - cr_cut);
                n_count = 8'd0;
                n_crs   = 8'd0;
            end else begin
                o_res.event_res = EV_STORED;
                n_count = cnt1;
                n_crs   = crs1;
            end
        end

        o_res_valid = i_fire && enabled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 8'd0;
            r_crs   <= 8'd0;
            r_disc  <= 1'b0;
        end else if (i_fire && enabled) begin
            r_count <= n_count;
            r_crs   <= n_crs;
            r_disc  <= n_disc;
        end
    end

    // While discarding, nothing of the dropped line is held.
    `BLC_ASSERT_IMP(a_disc_empty, i_clk, i_rst_n, r_disc, (r_count == 8'd0) && (r_crs == 8'd0))
    // The trailing CR run never reaches past the start of the line.
    `BLC_ASSERT_IMP(a_crs_bound, i_clk, i_rst_n, 1'b1, r_crs <= r_count)

endmodule

### rtl/blc_obuf.sv
// Output register with one skid entry, so input acceptance waits on the sink only once two
// results are held. Depends on blc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module blc_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  blc_pkg::t_result i_in_data,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output blc_pkg::t_result o_out_data,
    input  logic             i_out_ready
);
    import blc_pkg::*;

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;

    logic    n_out_v;
    logic    n_skid_v;
    logic    load_out;
    logic    load_skid;
    logic    out_take;

    always_comb begin
        out_take  = r_out_v && i_out_ready;
        n_out_v   = r_out_v;
        n_skid_v  = r_skid_v;
        load_out  = 1'b0;
        load_skid = 1'b0;
        if (r_skid_v) begin
            if (out_take) begin
                n_skid_v = 1'b0;
            end
        end else if (i_in_valid) begin
            if (!r_out_v || out_take) begin
                load_out = 1'b1;
                n_out_v  = 1'b1;
            end else begin
                load_skid = 1'b1;
                n_skid_v  = 1'b1;
            end
        end else if (out_take) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v && out_take) begin
            r_out <= r_skid;
        end else if (load_out) begin
            r_out <= i_in_data;
        end
        if (load_skid) begin
            r_skid <= i_in_data;
        end
    end

    assign o_in_ready  = !r_skid_v;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // The skid entry is only ever used behind a held output beat.
    `BLC_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    // A result parked in the skid entry moves to the output once that beat leaves.
    `BLC_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_v && i_out_ready, r_out_v && !r_skid_v)

endmodule

### rtl/bounded_line_collector.sv
// Top level of the bounded line collector: stream ports, config port and wiring.
// Depends on blc_pkg, blc_core and blc_obuf.

// The bounded line collector takes one received byte per beat and reports, one
// result beat per input beat, what happened to it: stored at an index of the
// current line, skipped while discarding, the partial line dropped, or the line
// completed with its length. The line text itself is kept downstream from
// store_index and byte_value. A byte is accepted every clock cycle while
// s_axis_tready is high; its result goes to the master side from an output
// register. s_axis_tready falls only when the sink has stalled for two results
// (the output register and its skid entry are both full), so a stall on the
// master side costs the input side at most that backlog. When the effective
// capacity (buffer_capacity, clamped to 256) is below 2, input beats are still
// accepted but produce no result and leave the line state untouched. There is
// no clearing pass after reset; the block is ready in the first cycle after
// reset is released. Configuration writes take effect at the clock edge that
// carries i_cfg_wen and are meant to happen only while no results are pending.
module bounded_line_collector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration: index 0 buffer_capacity (9 bits), index 1 keep_terminator.
    input  logic                            i_cfg_wen,
    input  logic [blc_pkg::C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [blc_pkg::C_CFG_W-1:0]     i_cfg_wdata,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  logic [0:0]                      s_axis_tuser,  // [0] raw_call
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,  // [7:0] store_index,
                                                           // [15:8] byte_value,
                                                           // [23:16] line_len
    output logic [2:0]                      m_axis_tuser   // [1:0] event_res,
                                                           // [2] byte_stored
);
    import blc_pkg::*;

    logic    fire;
    logic    res_valid;
    t_result res;
    t_result out_res;

    // An input beat is taken whenever the skid entry has room.
    assign fire = s_axis_tvalid && s_axis_tready;

    blc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_data_byte (s_axis_tdata),
        .i_raw_call  (s_axis_tuser[0]),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    blc_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (res_valid),
        .i_in_data   (res),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (out_res),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {out_res.line_len, out_res.byte_value, out_res.store_index};
    assign m_axis_tuser = {out_res.byte_stored, out_res.event_res};

endmodule

### tb/sv/tb_bounded_line_collector.sv
// Self-checking testbench for bounded_line_collector: random byte streams, config sweeps.
// Depends on blc_pkg and the bounded_line_collector RTL; it needs no other files.
module tb_bounded_line_collector;
    timeunit 1ns;
    timeprecision 1ps;

    import blc_pkg::*;

    // One byte of the received text stream, as it travels on the slave side.
    typedef struct packed {
        logic [7:0] data;
        logic       raw;
    } t_rx_byte;

    logic                    i_clk;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_wen     = 1'b0;
    logic [C_CFG_IDX_W-1:0]  i_cfg_idx     = CFG_CAPACITY;
    logic [C_CFG_W-1:0]      i_cfg_wdata   = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata  = '0;  // [7:0] data_byte
    logic [0:0]              s_axis_tuser  = '0;  // [0] raw_call
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [23:0]             m_axis_tdata;        // [7:0] store_index, [15:8] byte_value,
                                                  // [23:16] line_len
    logic [2:0]              m_axis_tuser;        // [1:0] event_res, [2] byte_stored

    bounded_line_collector uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Bytes waiting to be driven, and results predicted but not yet seen.
    t_rx_byte rx_pending[$];
    t_result  awaited_results[$];

    // Register mirror, updated by the sequence whenever it writes the block.
    logic [C_CFG_W-1:0] cfg_capacity = C_CAP_RESET;
    logic               cfg_keep     = 1'b0;

    // Line state of the predictor: bytes in the current line, the discard flag
    // and the number of CRs at the end of what has been stored so far.
    logic [7:0] line_count = '0;
    logic       in_discard = 1'b0;
    logic [7:0] cr_run     = '0;

    // Source and sink idling: when enabled, each side occasionally starts an
    // idle burst of random length.
    bit idle_on  = 1'b0;
    int src_gap  = 0;
    int sink_gap = 0;

    int bytes_queued  = 0;
    int bytes_taken   = 0;
    int results_seen  = 0;
    int error_count   = 0;
    int settings_used = 0;
    int event_count[4];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Works out the result of one accepted byte and advances the line state.
    // Returns 0 when the block is disabled by a capacity below two and the
    // byte produces nothing.
    function automatic bit collect_byte(input logic [7:0] b, input logic raw,
                                        output t_result r);
        logic        keep;
        logic        is_lf;
        int unsigned cap;
        int unsigned len;
        keep  = raw || cfg_keep;
        is_lf = (b == C_LF_BYTE);
        // Capacities above the design limit are clamped.
        cap   = (cfg_capacity > C_CAP_LIMIT) ? int'(C_CAP_LIMIT) : int'(cfg_capacity);
        r            = '0;
        r.event_res  = EV_STORED;
        r.byte_value = b;
        if (cap < 2) return 1'b0;

        if (in_discard) begin
            // Everything is skipped until the LF that ends the bad line.
            r.event_res = EV_SKIPPED;
            if (is_lf) in_discard = 1'b0;
        end else if (b == C_NUL_BYTE ||
                     (int'(line_count) >= cap - 1 && (!is_lf || keep))) begin
            // A NUL or a byte with no room left drops the line. An LF that
            // overflows ends the line itself, so there is nothing to skip.
            r.event_res = EV_DROPPED;
            line_count  = '0;
            cr_run      = '0;
            in_discard  = !is_lf;
        end else begin
            if (!is_lf || keep) begin
                r.byte_stored = 1'b1;
                r.store_index = line_count;
                line_count    = line_count + 8'd1;
                cr_run        = (b == C_CR_BYTE) ? cr_run + 8'd1 : 8'd0;
            end
            if (is_lf) begin
                r.event_res = EV_COMPLETE;
                len = {24'd0, line_count};
                // Without kept endings, trailing CRs do not count.
                if (!keep) len = len - ((cr_run <= len) ? cr_run : len);
                r.line_len = len[7:0];
                line_count = '0;
                cr_run     = '0;
            end
        end
        return 1'b1;
    endfunction

    // Source driver: presents the next pending byte once the current beat has
    // been taken, inserting idle bursts when enabled.
    always @(posedge i_clk) begin
        t_rx_byte item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_gap > 0) begin
                src_gap       <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (rx_pending.size() > 0) begin
                item = rx_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= item.data;
                s_axis_tuser  <= item.raw;
                if (idle_on && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 11);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink: ready most of the time, with stall bursts when enabled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap      <= sink_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 9) == 0) sink_gap <= $urandom_range(1, 11);
        end
    end

    // Monitor: predicts on every accepted input beat and checks every result
    // beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready === 1'b1) begin
                bytes_taken <= bytes_taken + 1;
                if (collect_byte(s_axis_tdata, s_axis_tuser[0], want))
                    awaited_results.push_back(want);
            end
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                got.event_res   = t_event'(m_axis_tuser[1:0]);
                got.byte_stored = m_axis_tuser[2];
                got.store_index = m_axis_tdata[7:0];
                got.byte_value  = m_axis_tdata[15:8];
                got.line_len    = m_axis_tdata[23:16];
                results_seen <= results_seen + 1;
                if (awaited_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %h", $time, got);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    event_count[want.event_res] <= event_count[want.event_res] + 1;
                    if (got.event_res !== want.event_res) begin
                        $display("%0t: event_res expected %0d actual %0d", $time,
                                 want.event_res, got.event_res);
                        error_count++;
                    end
                    if (got.byte_stored !== want.byte_stored) begin
                        $display("%0t: byte_stored expected %0d actual %0d", $time,
                                 want.byte_stored, got.byte_stored);
                        error_count++;
                    end
                    if (got.store_index !== want.store_index) begin
                        $display("%0t: store_index expected %0d actual %0d", $time,
                                 want.store_index, got.store_index);
                        error_count++;
                    end
                    if (got.byte_value !== want.byte_value) begin
                        $display("%0t: byte_value expected %h actual %h", $time,
                                 want.byte_value, got.byte_value);
                        error_count++;
                    end
                    if (got.line_len !== want.line_len) begin
                        $display("%0t: line_len expected %0d actual %0d", $time,
                                 want.line_len, got.line_len);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic raw);
        t_rx_byte item;
        item.data = b;
        item.raw  = raw;
        rx_pending.push_back(item);
        bytes_queued++;
    endtask

    // Any byte except NUL and LF, so that a line body never ends early.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        if (b == C_LF_BYTE) b = C_CR_BYTE;
        return b;
    endfunction

    // Waits until every byte has been taken and every result checked, then
    // lets the clock run on so that no beat is still inside the block.
    task automatic drain();
        while (bytes_taken != bytes_queued || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Register writes happen only while the block is idle; the mirror is
    // updated together with the write.
    task automatic set_register(input t_cfg_idx idx, input logic [C_CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        if (idx == CFG_CAPACITY) cfg_capacity = value;
        else cfg_keep = value[0];
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic configure(input logic [C_CFG_W-1:0] cap, input logic keep);
        drain();
        set_register(CFG_CAPACITY, cap);
        set_register(CFG_KEEP, {{(C_CFG_W-1){1'b0}}, keep});
        settings_used++;
    endtask

    // Random traffic: mostly well-formed lines whose lengths straddle the capacity
    // when it is at most 40, mixed with NUL bytes, bare line endings and raw noise.
    task automatic random_traffic(input int n_items);
        int stop_at;
        int lim;
        int len;
        int kind;
        bit raw_line;
        stop_at = bytes_queued + n_items;
        lim = (cfg_capacity > 40) ? 40 : int'(cfg_capacity) + 1;
        while (bytes_queued < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                raw_line = ($urandom_range(0, 4) == 0);
                len = $urandom_range(0, lim);
                repeat (len) push_byte(text_byte(), raw_line || $urandom_range(0, 7) == 0);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) push_byte(C_CR_BYTE, raw_line);
                push_byte(C_LF_BYTE, raw_line || $urandom_range(0, 5) == 0);
            end else if (kind == 7) begin
                // NUL in the middle of a line, followed by bytes to skip.
                repeat ($urandom_range(0, 3)) push_byte(text_byte(), 1'b0);
                push_byte(C_NUL_BYTE, 1'($urandom_range(0, 1)));
            end else if (kind == 8) begin
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                push_byte($urandom_range(0, 1) ? C_LF_BYTE : C_CR_BYTE,
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Sequence: directed cases first, then random phases under several
    // register settings, and a final phase without any idling.
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settings_used = 1;

        // Reset settings: CRs before LF are stripped, empty line, NUL drop
        // with skipping up to LF, raw feed keeping the ending.
        push_byte(8'h48, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(C_CR_BYTE, 1'b0);
        push_byte(C_CR_BYTE, 1'b0);
        push_byte(C_LF_BYTE, 1'b0);
        push_byte(C_LF_BYTE, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(C_NUL_BYTE, 1'b0);
        push_byte(8'h79, 1'b1);
        push_byte(C_LF_BYTE, 1'b0);
        push_byte(8'h61, 1'b1);
        push_byte(C_CR_BYTE, 1'b1);
        push_byte(C_LF_BYTE, 1'b1);

        // Capacity 4: a full line still completes on a plain LF, overflow
        // starts discarding, and a kept LF on a full line drops it.
        configure(9'd4, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h63, 1'b0);
        push_byte(C_LF_BYTE, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h63, 1'b0);
        push_byte(8'h64, 1'b0);
        push_byte(C_LF_BYTE, 1'b0);
        push_byte(8'h31, 1'b0);
        push_byte(8'h32, 1'b0);
        push_byte(8'h33, 1'b0);
        push_byte(C_LF_BYTE, 1'b1);

        // Kept endings: a line of CRs keeps its full length.
        configure(9'd4, 1'b1);
        push_byte(C_CR_BYTE, 1'b0);
        push_byte(C_CR_BYTE, 1'b0);
        push_byte(C_LF_BYTE, 1'b0);

        // Capacities below two disable the block; bytes give no result.
        configure(9'd1, 1'b0);
        repeat (4) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        configure(9'd0, 1'b1);
        repeat (4) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        idle_on = 1'b1;
        configure(9'd2, 1'b0);
        random_traffic(100);
        configure(9'd2, 1'b1);
        random_traffic(80);
        configure(9'd3, 1'b0);
        random_traffic(100);

        // Largest capacity: one line of 254 stored bytes plus a kept LF, one
        // line that overflows at the last slot, then ordinary traffic.
        configure(9'd256, 1'b0);
        repeat (254) push_byte(text_byte(), 1'b0);
        push_byte(C_LF_BYTE, 1'b1);
        repeat (256) push_byte(text_byte(), 1'b0);
        push_byte(C_LF_BYTE, 1'b0);
        random_traffic(60);

        // A capacity above the design limit is clamped.
        configure(9'd511, 1'b1);
        random_traffic(80);

        idle_on = 1'b0;
        configure(C_CFG_W'($urandom_range(5, 12)), 1'b0);
        random_traffic(100);

        idle_on = 1'b1;
        repeat (4) begin
            configure(C_CFG_W'($urandom_range(2, 24)), 1'($urandom_range(0, 1)));
            random_traffic(40);
        end

        // The last part of the run runs with both sides always ready.
        idle_on = 1'b0;
        configure(9'd8, 1'b0);
        random_traffic(100);

        drain();
        $display("Sent %0d bytes under %0d register settings and checked %0d results.",
                 bytes_queued, settings_used, results_seen);
        $display("Events: %0d stored, %0d skipped, %0d dropped, %0d lines completed.",
                 event_count[EV_STORED], event_count[EV_SKIPPED],
                 event_count[EV_DROPPED], event_count[EV_COMPLETE]);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Timeout with %0d results still expected.", awaited_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
